FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

FILE: hw/rtl/ethhp_pkg.sv
// ----------------------------------------------------------------------------
// ethhp_pkg
// Shared types and constants for the Ethernet/IPv4/TCP header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ethhp_pkg;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  ETH_HDR_LEN    = 8'd14;
    localparam logic [3:0]  MIN_HDR_WORDS  = 4'd5;
    localparam logic [7:0]  SUBST_CHAR     = 8'h2E;
    localparam logic [7:0]  PRINT_LOW      = 8'h20;
    localparam logic [7:0]  PRINT_HIGH     = 8'h7E;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PREVIEW = 1'b1;

    // One result produced by the parser for one frame byte.
    typedef struct packed {
        logic        valid;
        logic        kind;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  preview_char;
        logic        frame_done;
    } ethhp_result_t;

    // Map a payload byte to a printable character.
    function automatic logic [7:0] printable(input logic [7:0] b);
        printable = (b >= PRINT_LOW && b <= PRINT_HIGH) ? b : SUBST_CHAR;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ethernet_ipv4_tcp_header_parser_top.sv
// ----------------------------------------------------------------------------
// ethernet_ipv4_tcp_header_parser_top
// Ethernet/IPv4/TCP header parser with payload preview.
// ----------------------------------------------------------------------------
// The block takes one frame byte per cycle and keeps up with that rate for
// as long as the result side accepts. A byte passes an input register, one
// step of parsing logic and a result register, from which its result is
// presented to the result side; the result register's ready is the only
// thing that stalls the input. A TCP/IPv4 frame yields one header record on
// its last TCP header byte (tuser 0), then up to cfg preview_limit payload
// characters (tuser 1); tlast marks the final result of a frame. Frames of
// other types, with a header length below five words, or that end early
// produce nothing. Write preview_limit only while the block is idle.
`default_nettype none

module ethernet_ipv4_tcp_header_parser_top
    import ethhp_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // configuration: preview_limit
    input  wire logic         cfg_wr_en,
    input  wire logic [7:0]   cfg_wr_data,
    // frame bytes in
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] frame_byte
    input  wire logic         s_tlast,   // frame_last
    // results out
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [199:0]      m_tdata,   // [47:0] src_mac, [95:48] dst_mac,
                                         // [127:96] src_ip, [159:128] dst_ip,
                                         // [175:160] src_port,
                                         // [191:176] dst_port,
                                         // [199:192] preview_char
    output logic              m_tuser,   // [0] kind
    output logic              m_tlast    // frame_done
);

    `include "assert_macros.svh"

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          in_last_reg;
    logic [7:0]    limit_reg;
    logic          out_valid_reg;
    logic [199:0]  out_data_reg;
    logic          out_kind_reg;
    logic          out_done_reg;
    logic          out_ready;
    logic          item_fire;
    ethhp_result_t result;

    assign out_ready = !out_valid_reg || m_tready;
    assign item_fire = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    // Preview limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= 8'd20;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    // Input register: hold a byte until the parse step can take it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    ethhp_parse u_parse (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_fire     (item_fire),
        .item_byte     (in_byte_reg),
        .item_last     (in_last_reg),
        .preview_limit (limit_reg),
        .result        (result)
    );

    // Result register: load a new result whenever the slot is free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && result.valid) begin
            out_data_reg <= {result.preview_char, result.dst_port, result.src_port,
                             result.dst_ip, result.src_ip, result.dst_mac,
                             result.src_mac};
            out_kind_reg <= result.kind;
            out_done_reg <= result.frame_done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_done_reg;

    // Checks
    `ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid,
                   "result valid after reset")
    `ASSERT_CLK(a_preview_no_addr, aclk, aresetn,
                (m_tvalid && m_tuser == KIND_PREVIEW) |-> m_tdata[191:0] == '0,
                "preview result carries address fields")
    `ASSERT_CLK(a_header_no_char, aclk, aresetn,
                (m_tvalid && m_tuser == KIND_HEADER) |-> m_tdata[199:192] == 8'd0,
                "header record carries a preview character")
    `ASSERT_CLK(a_char_printable, aclk, aresetn,
                (m_tvalid && m_tuser == KIND_PREVIEW) |->
                    (m_tdata[199:192] >= PRINT_LOW && m_tdata[199:192] <= PRINT_HIGH),
                "preview character not printable")

endmodule

`default_nettype wire

FILE: hw/rtl/ethhp_parse.sv
// ----------------------------------------------------------------------------
// ethhp_parse
// Frame parsing state and the per-byte decision logic. Consumes one byte on
// each item_fire and reports the result that byte causes, if any.
// ----------------------------------------------------------------------------
`default_nettype none

module ethhp_parse
    import ethhp_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          item_fire,
    input  wire logic [7:0]    item_byte,
    input  wire logic          item_last,
    input  wire logic [7:0]    preview_limit,
    output ethhp_result_t      result
);

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_DROP    = 2'd2;

    localparam logic [7:0] POS_SRC_MAC  = 8'd6;
    localparam logic [7:0] POS_ETH_LAST = ETH_HDR_LEN - 8'd1;
    localparam logic [7:0] POS_PROTO    = ETH_HDR_LEN + 8'd9;
    localparam logic [7:0] POS_SRC_IP   = ETH_HDR_LEN + 8'd12;
    localparam logic [7:0] POS_DST_IP   = ETH_HDR_LEN + 8'd16;
    localparam logic [7:0] POS_IP_END   = ETH_HDR_LEN + 8'd20;
    localparam logic [7:0] REL_OFFSET   = 8'd12;
    localparam logic [7:0] REL_PORTS    = 8'd4;

    logic [7:0]  pos_reg, pos_next;
    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [15:0] eth_type_reg, eth_type_next;
    logic [5:0]  ip_len_reg, ip_len_next;
    logic [5:0]  tcp_len_reg, tcp_len_next;
    logic [47:0] src_mac_reg, src_mac_next;
    logic [47:0] dst_mac_reg, dst_mac_next;
    logic [31:0] src_ip_reg, src_ip_next;
    logic [31:0] dst_ip_reg, dst_ip_next;
    logic [31:0] ports_reg, ports_next;

    logic [7:0]  tcp_start;
    logic [7:0]  rel;
    logic [7:0]  cnt_inc;
    logic        hdr_done;
    logic        drop;

    assign tcp_start = ETH_HDR_LEN + {2'b00, ip_len_reg};
    assign rel       = pos_reg - tcp_start;
    assign cnt_inc   = cnt_reg + 8'd1;

    // Decide the result and the next state for the byte at the input stage.
    always_comb begin
        pos_next      = pos_reg;
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        eth_type_next = eth_type_reg;
        ip_len_next   = ip_len_reg;
        tcp_len_next  = tcp_len_reg;
        src_mac_next  = src_mac_reg;
        dst_mac_next  = dst_mac_reg;
        src_ip_next   = src_ip_reg;
        dst_ip_next   = dst_ip_reg;
        ports_next    = ports_reg;
        hdr_done      = 1'b0;
        drop          = 1'b0;
        result        = '0;

        unique case (phase_reg)
            PH_HEADER: begin
                // Collect header fields by byte position
                if (pos_reg < POS_SRC_MAC) begin
                    dst_mac_next = {dst_mac_reg[39:0], item_byte};
                end else if (pos_reg < ETH_HDR_LEN - 8'd2) begin
                    src_mac_next = {src_mac_reg[39:0], item_byte};
                end else if (pos_reg < ETH_HDR_LEN) begin
                    eth_type_next = {eth_type_reg[7:0], item_byte};
                    if (pos_reg == POS_ETH_LAST && eth_type_next != ETHERTYPE_IPV4) begin
                        drop = 1'b1;
                    end
                end else if (pos_reg == ETH_HDR_LEN) begin
                    if (item_byte[3:0] < MIN_HDR_WORDS) begin
                        drop = 1'b1;
                    end else begin
                        ip_len_next = {item_byte[3:0], 2'b00};
                    end
                end else if (pos_reg == POS_PROTO && item_byte != PROTO_TCP) begin
                    drop = 1'b1;
                end else begin
                    if (pos_reg >= POS_SRC_IP && pos_reg < POS_DST_IP) begin
                        src_ip_next = {src_ip_reg[23:0], item_byte};
                    end else if (pos_reg >= POS_DST_IP && pos_reg < POS_IP_END) begin
                        dst_ip_next = {dst_ip_reg[23:0], item_byte};
                    end
                    // TCP header: ports, data offset, end of header
                    if (pos_reg >= tcp_start) begin
                        if (rel < REL_PORTS) begin
                            ports_next = {ports_reg[23:0], item_byte};
                        end else if (rel == REL_OFFSET) begin
                            if (item_byte[7:4] < MIN_HDR_WORDS) begin
                                drop = 1'b1;
                            end else begin
                                tcp_len_next = {item_byte[7:4], 2'b00};
                            end
                        end else if (rel > REL_OFFSET
                                     && rel == {2'b00, tcp_len_reg} - 8'd1) begin
                            hdr_done = 1'b1;
                        end
                    end
                end

                if (hdr_done) begin
                    result.valid      = 1'b1;
                    result.kind       = KIND_HEADER;
                    result.src_mac    = src_mac_reg;
                    result.dst_mac    = dst_mac_reg;
                    result.src_ip     = src_ip_reg;
                    result.dst_ip     = dst_ip_reg;
                    result.src_port   = ports_reg[31:16];
                    result.dst_port   = ports_reg[15:0];
                    result.frame_done = item_last || (preview_limit == 8'd0);
                    phase_next        = PH_PAYLOAD;
                    cnt_next          = 8'd0;
                end else if (drop) begin
                    phase_next = PH_DROP;
                end else begin
                    pos_next = pos_reg + 8'd1;
                end
            end
            PH_PAYLOAD: begin
                // Emit preview characters up to the limit
                if (cnt_reg < preview_limit) begin
                    cnt_next            = cnt_inc;
                    result.valid        = 1'b1;
                    result.kind         = KIND_PREVIEW;
                    result.preview_char = printable(item_byte);
                    result.frame_done   = item_last || (cnt_inc == preview_limit);
                end
            end
            default: begin
                // Drop the rest of the frame
            end
        endcase

        // Return to the start of a frame after its last byte
        if (item_last) begin
            phase_next = PH_HEADER;
            pos_next   = 8'd0;
        end

        result.valid = result.valid && item_fire;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= 8'd0;
            phase_reg <= PH_HEADER;
            cnt_reg   <= 8'd0;
        end else if (item_fire) begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Captured header fields
    always_ff @(posedge aclk) begin
        if (item_fire) begin
            eth_type_reg <= eth_type_next;
            ip_len_reg   <= ip_len_next;
            tcp_len_reg  <= tcp_len_next;
            src_mac_reg  <= src_mac_next;
            dst_mac_reg  <= dst_mac_next;
            src_ip_reg   <= src_ip_next;
            dst_ip_reg   <= dst_ip_next;
            ports_reg    <= ports_next;
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/ethhp_tb_pkg.sv
// ----------------------------------------------------------------------------
// ethhp_tb_pkg
// Frame-parse predictor and result scoreboard for the header parser bench.
// ----------------------------------------------------------------------------
`default_nettype none

package ethhp_tb_pkg;

    import ethhp_pkg::*;

    typedef enum logic [1:0] {
        PARSE_HEADER,
        PARSE_PAYLOAD,
        PARSE_DROP
    } parse_phase_t;

    typedef logic [7:0] frame_bytes_t[$];

    // One result transaction, field by field.
    typedef struct {
        logic        kind;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  preview_char;
        logic        frame_done;
    } parse_record_t;

    class tcp_header_scoreboard;
        logic [7:0]    preview_limit;
        logic [7:0]    byte_pos;
        parse_phase_t  phase;
        logic [15:0]   ethertype;
        logic [5:0]    ip_hdr_bytes;
        logic [5:0]    tcp_hdr_bytes;
        logic [47:0]   src_mac;
        logic [47:0]   dst_mac;
        logic [31:0]   src_ip;
        logic [31:0]   dst_ip;
        logic [31:0]   port_pair;
        logic [7:0]    payload_count;
        parse_record_t expected_records[$];
        int            mismatches;

        function new();
            preview_limit = 8'd20;
            byte_pos      = '0;
            phase         = PARSE_HEADER;
            ethertype     = '0;
            ip_hdr_bytes  = '0;
            tcp_hdr_bytes = '0;
            src_mac       = '0;
            dst_mac       = '0;
            src_ip        = '0;
            dst_ip        = '0;
            port_pair     = '0;
            payload_count = '0;
            mismatches    = 0;
        endfunction

        function void set_limit(logic [7:0] value);
            preview_limit = value;
        endfunction

        function int pending();
            return expected_records.size();
        endfunction

        // Advance the parse by one accepted frame byte and queue what it yields.
        function void note_frame_byte(logic [7:0] b, logic last);
            parse_record_t rec;
            logic          header_done;
            int            tcp_start;
            int            rel;
            rec = '{default: '0};
            header_done = 1'b0;
            if (phase == PARSE_HEADER) begin
                if (byte_pos < 8'd6) begin
                    dst_mac = {dst_mac[39:0], b};
                end else if (byte_pos < 8'd12) begin
                    src_mac = {src_mac[39:0], b};
                end else if (byte_pos < ETH_HDR_LEN) begin
                    ethertype = {ethertype[7:0], b};
                    if (byte_pos == ETH_HDR_LEN - 8'd1 && ethertype != ETHERTYPE_IPV4) begin
                        phase = PARSE_DROP;
                    end
                end else if (byte_pos == ETH_HDR_LEN) begin
                    // IHL sits in the low nibble of the first IP byte
                    if (b[3:0] < MIN_HDR_WORDS) begin
                        phase = PARSE_DROP;
                    end else begin
                        ip_hdr_bytes = {b[3:0], 2'b00};
                    end
                end else if (byte_pos == ETH_HDR_LEN + 8'd9 && b != PROTO_TCP) begin
                    phase = PARSE_DROP;
                end else begin
                    if (byte_pos >= ETH_HDR_LEN + 8'd12 && byte_pos < ETH_HDR_LEN + 8'd16) begin
                        src_ip = {src_ip[23:0], b};
                    end else if (byte_pos >= ETH_HDR_LEN + 8'd16 &&
                                 byte_pos < ETH_HDR_LEN + 8'd20) begin
                        dst_ip = {dst_ip[23:0], b};
                    end
                    tcp_start = int'(ETH_HDR_LEN) + int'(ip_hdr_bytes);
                    rel = int'(byte_pos) - tcp_start;
                    if (rel >= 0 && rel < 4) begin
                        port_pair = {port_pair[23:0], b};
                    end else if (rel == 12) begin
                        // data offset sits in the high nibble
                        if (b[7:4] < MIN_HDR_WORDS) begin
                            phase = PARSE_DROP;
                        end else begin
                            tcp_hdr_bytes = {b[7:4], 2'b00};
                        end
                    end else if (rel > 12 && rel == int'(tcp_hdr_bytes) - 1) begin
                        header_done = 1'b1;
                    end
                end

                if (header_done) begin
                    rec.kind       = KIND_HEADER;
                    rec.src_mac    = src_mac;
                    rec.dst_mac    = dst_mac;
                    rec.src_ip     = src_ip;
                    rec.dst_ip     = dst_ip;
                    rec.src_port   = port_pair[31:16];
                    rec.dst_port   = port_pair[15:0];
                    rec.frame_done = last || preview_limit == 8'd0;
                    expected_records.push_back(rec);
                    phase = PARSE_PAYLOAD;
                    payload_count = '0;
                end else if (phase == PARSE_HEADER) begin
                    byte_pos = byte_pos + 8'd1;
                end
            end else if (phase == PARSE_PAYLOAD) begin
                if (payload_count < preview_limit) begin
                    payload_count = payload_count + 8'd1;
                    rec.kind = KIND_PREVIEW;
                    rec.preview_char = (b >= PRINT_LOW && b <= PRINT_HIGH) ? b : SUBST_CHAR;
                    rec.frame_done = last || payload_count == preview_limit;
                    expected_records.push_back(rec);
                end
            end

            // frame end always rewinds to the Ethernet header
            if (last) begin
                phase = PARSE_HEADER;
                byte_pos = '0;
            end
        endfunction

        task report_mismatch(string msg);
            if (mismatches < 50) begin
                $display("[%0t] mismatch: %s", $time, msg);
            end
            mismatches++;
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
            end
        endtask

        // Compare one accepted result with the oldest expectation.
        task check_result(parse_record_t got);
            parse_record_t want;
            if (expected_records.size() == 0) begin
                report_mismatch("result transaction with nothing expected");
            end else begin
                want = expected_records.pop_front();
                compare_field("kind",         got.kind,         want.kind);
                compare_field("src_mac",      got.src_mac,      want.src_mac);
                compare_field("dst_mac",      got.dst_mac,      want.dst_mac);
                compare_field("src_ip",       got.src_ip,       want.src_ip);
                compare_field("dst_ip",       got.dst_ip,       want.dst_ip);
                compare_field("src_port",     got.src_port,     want.src_port);
                compare_field("dst_port",     got.dst_port,     want.dst_port);
                compare_field("preview_char", got.preview_char, want.preview_char);
                compare_field("frame_done",   got.frame_done,   want.frame_done);
            end
        endtask

        task flush_leftovers();
            if (expected_records.size() != 0) begin
                report_mismatch($sformatf("%0d expected results never arrived",
                                          expected_records.size()));
                expected_records.delete();
            end
        endtask
    endclass

endpackage

`default_nettype wire

FILE: tb/sv/ethernet_ipv4_tcp_header_parser_top_tb.sv
// ----------------------------------------------------------------------------
// ethernet_ipv4_tcp_header_parser_top_tb
// Streams Ethernet frames byte by byte into the parser and checks every header
// record and payload character against a cycle-free parse predictor, under
// random gaps, random back-pressure and a long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ethernet_ipv4_tcp_header_parser_top_tb
    import ethhp_pkg::*;
    import ethhp_tb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 6000;
    localparam int RANDOM_BYTES  = 400;
    localparam int MIN_FRAME_HDR = 54;

    logic         aclk        = 1'b0;
    logic         aresetn     = 1'b0;
    logic         cfg_wr_en   = 1'b0;
    logic [7:0]   cfg_wr_data = '0;
    logic         s_tvalid    = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata     = '0;
    logic         s_tlast     = 1'b0;
    logic         m_tvalid;
    logic         m_tready    = 1'b0;
    logic [199:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;

    tcp_header_scoreboard frame_sb = new();
    bit                   long_hold_req = 1'b0;

    ethernet_ipv4_tcp_header_parser_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Mostly short idle stretches, a few long ones.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 8);
        end
        return $urandom_range(20, 40);
    endfunction

    // Build a well-formed TCP/IPv4 frame with random content.
    function automatic frame_bytes_t build_tcp_frame(int ihl, int off, int body_len);
        frame_bytes_t f;
        f = {};
        repeat (12) f.push_back(8'($urandom_range(0, 255)));
        f.push_back(ETHERTYPE_IPV4[15:8]);
        f.push_back(ETHERTYPE_IPV4[7:0]);
        f.push_back({4'($urandom_range(0, 15)), 4'(ihl)});
        for (int i = 1; i < ihl * 4; i++) begin
            f.push_back(i == 9 ? PROTO_TCP : 8'($urandom_range(0, 255)));
        end
        for (int i = 0; i < off * 4; i++) begin
            f.push_back(i == 12 ? {4'(off), 4'($urandom_range(0, 15))}
                                : 8'($urandom_range(0, 255)));
        end
        // bias half the payload toward printable text
        for (int i = 0; i < body_len; i++) begin
            f.push_back($urandom_range(0, 1) ? 8'($urandom_range(32, 126))
                                             : 8'($urandom_range(0, 255)));
        end
        return f;
    endfunction

    // Overwrite both MACs, both IPs and both ports with one fill byte each.
    function automatic frame_bytes_t fill_addresses(frame_bytes_t f, int ihl,
                                                    logic [7:0] mac_fill,
                                                    logic [7:0] ip_fill,
                                                    logic [7:0] port_fill);
        for (int i = 0; i < 12; i++) f[i] = mac_fill;
        for (int i = 26; i < 34; i++) f[i] = ip_fill;
        for (int i = 0; i < 4; i++) f[14 + ihl * 4 + i] = port_fill;
        return f;
    endfunction

    // Offer one byte and hold it until the parser takes the transaction.
    task automatic send_byte(logic [7:0] b, logic last, bit gappy);
        int gap;
        gap = (gappy && $urandom_range(0, 99) >= 55) ? idle_length() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= b;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        frame_sb.note_frame_byte(b, last);
    endtask

    // Send count bytes of a frame from index first; mark the final one if asked.
    task automatic send_span(frame_bytes_t f, int first, int count, bit mark_last);
        bit gappy;
        gappy = $urandom_range(0, 3) != 0;
        for (int i = first; i < first + count; i++) begin
            send_byte(f[i], mark_last && i == first + count - 1, gappy);
        end
    endtask

    task automatic send_frame(frame_bytes_t f);
        send_span(f, 0, f.size(), 1'b1);
    endtask

    // Drop valid, wait for every expected result, then let the pipe empty.
    task automatic settle();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (frame_sb.pending() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        frame_sb.flush_leftovers();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(logic [7:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        frame_sb.set_limit(value);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic int pick_hdr_words();
        return ($urandom_range(0, 99) < 70) ? 5 : $urandom_range(6, 15);
    endfunction

    // Send one random frame: mostly well-formed, sometimes broken or noise.
    // Returns the number of bytes sent.
    task automatic send_random_frame(output int sent);
        frame_bytes_t f;
        int           ihl;
        int           off;
        int           plen;
        int           r;
        int           span;
        ihl = pick_hdr_words();
        off = pick_hdr_words();
        r = $urandom_range(0, 99);
        plen = (r < 70) ? $urandom_range(0, 24) :
               (r < 97) ? $urandom_range(25, 60) : $urandom_range(100, 280);
        f = build_tcp_frame(ihl, off, plen);
        sent = 0;
        if ($urandom_range(0, 99) < 80) begin
            send_frame(f);
            sent = f.size();
        end else begin
            case ($urandom_range(0, 5))
                0: begin
                    f[12] = 8'($urandom_range(0, 255));
                    if (f[12] == ETHERTYPE_IPV4[15:8]) f[13] = 8'h01;
                    send_frame(f);
                    sent = f.size();
                end
                1: begin
                    f[23] = 8'($urandom_range(0, 255));
                    if (f[23] == PROTO_TCP) f[23] = 8'd17;
                    send_frame(f);
                    sent = f.size();
                end
                2: begin
                    f[14] = {f[14][7:4], 4'($urandom_range(0, 4))};
                    send_frame(f);
                    sent = f.size();
                end
                3: begin
                    f[26 + ihl * 4] = {4'($urandom_range(0, 4)), f[26 + ihl * 4][3:0]};
                    send_frame(f);
                    sent = f.size();
                end
                4: begin
                    span = $urandom_range(1, 14 + ihl * 4 + off * 4 - 1);
                    send_span(f, 0, span, 1'b1);
                    sent = span;
                end
                default: begin
                    f = {};
                    repeat ($urandom_range(1, 60)) f.push_back(8'($urandom_range(0, 255)));
                    send_frame(f);
                    sent = f.size();
                end
            endcase
        end
    endtask

    // Result side: check accepted transactions, then pick next tready.
    initial begin : result_sink
        parse_record_t got;
        int            hold_left;
        int            stall_left;
        int            mode_left;
        bit            stall_often;
        hold_left   = 0;
        stall_left  = 0;
        mode_left   = 0;
        stall_often = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.kind         = m_tuser;
                got.src_mac      = m_tdata[47:0];
                got.dst_mac      = m_tdata[95:48];
                got.src_ip       = m_tdata[127:96];
                got.dst_ip       = m_tdata[159:128];
                got.src_port     = m_tdata[175:160];
                got.dst_port     = m_tdata[191:176];
                got.preview_char = m_tdata[199:192];
                got.frame_done   = m_tlast;
                frame_sb.check_result(got);
            end
            if (long_hold_req) begin
                hold_left = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (mode_left == 0) begin
                stall_often = $urandom_range(0, 3) != 0;
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (stall_often && $urandom_range(0, 99) < 30) begin
                m_tready <= 1'b0;
                stall_left = idle_length() - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Stimulus: directed frames, then random phases at several limits.
    initial begin : frame_source
        frame_bytes_t f;
        int           sent;
        int           phase_bytes;
        logic [7:0]   phase_limits[5];
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // header ends on the last byte, all-ones and all-zeros addresses
        f = fill_addresses(build_tcp_frame(5, 5, 0), 5, 8'hFF, 8'h00, 8'hFF);
        send_frame(f);
        // longest headers, printable edges in payload, limit reached
        f = fill_addresses(build_tcp_frame(15, 15, 30), 15, 8'h00, 8'hFF, 8'h00);
        f[134] = 8'h00; f[135] = 8'h1F; f[136] = 8'h20; f[137] = 8'h7E;
        f[138] = 8'h7F; f[139] = 8'hFF; f[140] = 8'h2E; f[141] = 8'h41;
        send_frame(f);
        // other ethertype
        f = build_tcp_frame(5, 5, 4);
        f[12] = 8'h86; f[13] = 8'hDD;
        send_frame(f);
        // other protocol
        f = build_tcp_frame(5, 5, 4);
        f[23] = 8'd17;
        send_frame(f);
        // IP header length below five words
        f = build_tcp_frame(5, 5, 4);
        f[14] = 8'h44;
        send_frame(f);
        f[14] = 8'h40;
        send_frame(f);
        // TCP data offset below five words
        f = build_tcp_frame(5, 5, 4);
        f[46] = 8'h4F;
        send_frame(f);
        // frames that end before the TCP header completes
        f = build_tcp_frame(5, 5, 4);
        send_span(f, 0, 30, 1'b1);
        send_span(f, 0, 1, 1'b1);
        send_span(f, 0, MIN_FRAME_HDR - 1, 1'b1);
        // payload ends before the limit
        send_frame(build_tcp_frame(6, 7, 3));
        settle();

        // zero limit: header record closes the frame
        write_limit(8'd0);
        send_frame(build_tcp_frame(5, 5, 5));
        settle();
        // widest limit, reached exactly
        write_limit(8'd255);
        send_frame(build_tcp_frame(5, 5, 260));
        settle();
        write_limit(8'd1);
        send_frame(build_tcp_frame(5, 5, 4));
        settle();
        // lower the limit below the count already sent, mid-frame
        write_limit(8'd10);
        f = build_tcp_frame(5, 5, 12);
        send_span(f, 0, MIN_FRAME_HDR + 5, 1'b0);
        settle();
        write_limit(8'd3);
        send_span(f, MIN_FRAME_HDR + 5, f.size() - MIN_FRAME_HDR - 5, 1'b1);
        settle();

        // random phases, each at its own limit
        phase_limits[0] = 8'($urandom_range(2, 30));
        phase_limits[1] = 8'd0;
        phase_limits[2] = 8'd255;
        phase_limits[3] = 8'($urandom_range(0, 255));
        phase_limits[4] = 8'd1;
        for (int p = 0; p < 5; p++) begin
            write_limit(phase_limits[p]);
            // hold the receiver off while frames keep coming
            if (p == 0 || p == 2) long_hold_req = 1'b1;
            phase_bytes = 0;
            while (phase_bytes < RANDOM_BYTES / 5) begin
                send_random_frame(sent);
                phase_bytes += sent;
            end
            settle();
        end

        if (frame_sb.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Abort a hung run.
    initial begin : watchdog
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/ethhp_pkg.sv
hw/rtl/ethhp_parse.sv
hw/rtl/ethernet_ipv4_tcp_header_parser_top.sv
tb/sv/ethhp_tb_pkg.sv
tb/sv/ethernet_ipv4_tcp_header_parser_top_tb.sv
